// File: src/iir_df2_first_order_filter_core_defines.svh
// Assertion macros shared by the filter core.
`ifndef IIR_DF2_FIRST_ORDER_FILTER_CORE_DEFINES_SVH
`define IIR_DF2_FIRST_ORDER_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define IIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/iir_df2_pkg.sv
// Package: widths, register indexes, state and command types, helper functions.
package iir_df2_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int IN_BITS     = 12;
    localparam int COEF_BITS   = 12;
    localparam int OUT_BITS    = 13;
    localparam int CNT_BITS    = 16;
    localparam int W_BITS      = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = W_BITS + COEF_BITS;
    localparam int SHIFT       = SAMPLE_BITS - 1;
    localparam int SH_BITS     = PROD_BITS - SHIFT;
    localparam int WIDE_BITS   = SH_BITS + 2;
    localparam int S_DATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((OUT_BITS + CNT_BITS + 7) / 8) * 8;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic signed [COEF_BITS-1:0] B0_RESET = 12'sd861;
    localparam logic signed [COEF_BITS-1:0] B1_RESET = 12'sd861;
    localparam logic signed [COEF_BITS-1:0] A1_RESET = -12'sd325;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_B0 = 2'd0,
        REG_B1 = 2'd1,
        REG_A1 = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_SUM1,
        ST_MUL2,
        ST_SUM2
    } state_t;

    typedef struct packed {
        logic load_x;
        logic mul1;
        logic sum1;
        logic mul2;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } sts_t;

    // Wrap to the sample range: sign bit above the low SAMPLE_BITS bits.
    function automatic logic signed [W_BITS-1:0] trunc_w(logic signed [WIDE_BITS-1:0] v);
        trunc_w = {v[WIDE_BITS-1], v[SAMPLE_BITS-1:0]};
    endfunction

    // High when wrapping changes the value.
    function automatic logic wraps(logic signed [WIDE_BITS-1:0] v);
        logic [WIDE_BITS-W_BITS:0] top;
        top = v[WIDE_BITS-1:W_BITS-1];
        wraps = !((top == '0) || (top == '1));
    endfunction

    function automatic logic [CNT_BITS-1:0] sat_add(logic [CNT_BITS-1:0] total,
                                                    logic [1:0] inc);
        logic [CNT_BITS:0] sum;
        sum = {1'b0, total} + (CNT_BITS+1)'(inc);
        sat_add = sum[CNT_BITS] ? '1 : sum[CNT_BITS-1:0];
    endfunction

endpackage

// File: src/iir_df2_ctrl.sv
// Controller: sequences one item through multiply and sum steps.
module iir_df2_ctrl
    import iir_df2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_x = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_SUM1;
            end
            ST_SUM1:
            begin
                cmd.sum1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                // hold until the output slot frees up
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/iir_df2_datapath.sv
// Datapath: coefficients, filter state, multipliers, wrap logic and output register.
module iir_df2_datapath
    import iir_df2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COEF_BITS-1:0]     cfg_data,
    input  logic [S_DATA_BITS-1:0]   s_tdata,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_DATA_BITS-1:0]   m_tdata
);

    logic signed [COEF_BITS-1:0] coef_b0_reg;
    logic signed [COEF_BITS-1:0] coef_b1_reg;
    logic signed [COEF_BITS-1:0] coef_a1_reg;
    logic signed [W_BITS-1:0]    w1_reg;
    logic [CNT_BITS-1:0]         total_reg;
    logic                        out_valid_reg;

    logic signed [IN_BITS-1:0]   x_reg;
    logic signed [PROD_BITS-1:0] pa_reg;
    logic signed [PROD_BITS-1:0] pb_reg;
    logic signed [PROD_BITS-1:0] p0_reg;
    logic signed [W_BITS-1:0]    ff_reg;
    logic signed [W_BITS-1:0]    w_reg;
    logic signed [OUT_BITS-1:0]  y_reg;
    logic [CNT_BITS-1:0]         cnt_out_reg;

    logic signed [SH_BITS-1:0]   sh_a;
    logic signed [SH_BITS-1:0]   sh_b;
    logic signed [SH_BITS-1:0]   sh_0;
    logic signed [WIDE_BITS-1:0] neg_a;
    logic signed [WIDE_BITS-1:0] ff_wide;
    logic signed [W_BITS-1:0]    fb;
    logic signed [WIDE_BITS-1:0] w_sum;
    logic signed [WIDE_BITS-1:0] y_sum;
    logic [1:0]                  wrap1_n;
    logic [CNT_BITS-1:0]         total_sum1;
    logic [CNT_BITS-1:0]         total_sum2;

    // floor shift: drop the low SHIFT bits
    assign sh_a = pa_reg[PROD_BITS-1:SHIFT];
    assign sh_b = pb_reg[PROD_BITS-1:SHIFT];
    assign sh_0 = p0_reg[PROD_BITS-1:SHIFT];

    assign neg_a   = -WIDE_BITS'(sh_a);
    assign ff_wide = WIDE_BITS'(sh_b);
    assign fb      = trunc_w(neg_a);
    assign w_sum   = WIDE_BITS'(x_reg) + WIDE_BITS'(fb);
    assign wrap1_n = 2'(wraps(neg_a)) + 2'(wraps(ff_wide)) + 2'(wraps(w_sum));
    assign total_sum1 = sat_add(total_reg, wrap1_n);

    assign y_sum      = WIDE_BITS'(sh_0) + WIDE_BITS'(ff_reg);
    assign total_sum2 = sat_add(total_reg, 2'(wraps(y_sum)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg   <= B0_RESET;
            coef_b1_reg   <= B1_RESET;
            coef_a1_reg   <= A1_RESET;
            w1_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_B0:  coef_b0_reg <= cfg_data;
                    REG_B1:  coef_b1_reg <= cfg_data;
                    REG_A1:  coef_a1_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.sum1)
            begin
                w1_reg    <= trunc_w(w_sum);
                total_reg <= total_sum1;
            end
            else if (cmd.load_out)
            begin
                total_reg <= total_sum2;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg <= s_tdata[IN_BITS-1:0];
        end
        if (cmd.mul1)
        begin
            pa_reg <= PROD_BITS'(w1_reg) * PROD_BITS'(coef_a1_reg);
            pb_reg <= PROD_BITS'(w1_reg) * PROD_BITS'(coef_b1_reg);
        end
        if (cmd.sum1)
        begin
            ff_reg <= trunc_w(ff_wide);
            w_reg  <= trunc_w(w_sum);
        end
        if (cmd.mul2)
        begin
            p0_reg <= PROD_BITS'(w_reg) * PROD_BITS'(coef_b0_reg);
        end
        if (cmd.load_out)
        begin
            y_reg       <= OUT_BITS'(trunc_w(y_sum));
            cnt_out_reg <= total_sum2;
        end
    end

    assign sts.out_full = out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = M_DATA_BITS'({cnt_out_reg, y_reg});

endmodule

// File: src/iir_df2_first_order_filter_core.sv
// Top level: first-order direct-form-II filter core, controller plus datapath.
//
//  channel   direction  payload
//  s_*       in         sample_in (12b signed)
//  m_*       out        sample_out (13b signed), overflow_count (16b)
//  cfg_*     in         coef_b0 / coef_b1 / coef_a1 (12b signed, Q11)
//
// An item is accepted in the idle state, then come a multiply step, a sum
// step, a second multiply step and a final sum step that loads the output
// register and raises m_tvalid; the next item can be taken the cycle after
// that load.
// A result waiting on m_tready does not block acceptance of the next item; it
// only holds the final load step. Reset clears the state, counter and control.
`include "iir_df2_first_order_filter_core_defines.svh"

module iir_df2_first_order_filter_core
    import iir_df2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COEF_BITS-1:0]     cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_DATA_BITS-1:0]   s_tdata,   // [11:0] sample_in
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_DATA_BITS-1:0]   m_tdata    // [12:0] sample_out, [28:13] overflow_count
);

    cmd_t cmd;
    sts_t sts;

    iir_df2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    iir_df2_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `IIR_ASSERT_NEXT(a_accept_starts, clk, rst_n, s_tvalid && s_tready, cmd.mul1 && !s_tready)
    `IIR_ASSERT_IMPLY(a_load_free, clk, rst_n, cmd.load_out, !sts.out_full)
    `IIR_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load_out, m_tvalid)
    `IIR_ASSERT_IMPLY(a_one_cmd, clk, rst_n, 1'b1,
        $onehot0({cmd.load_x, cmd.mul1, cmd.sum1, cmd.mul2, cmd.load_out}))

endmodule

// File: verif/tb_top.sv
// Self-checking bench for the first-order filter core: streamed samples against a local predictor.
module tb_top
    import iir_df2_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int WRAP_ITEMS  = 60;

    typedef struct {
        logic signed [OUT_BITS-1:0] sample;
        logic [CNT_BITS-1:0]        count;
    } filter_out_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [COEF_BITS-1:0]     cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_DATA_BITS-1:0]   s_tdata = '0;    // [11:0] sample_in
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]   m_tdata;         // [12:0] sample_out, [28:13] overflow_count

    // Predictor state and coefficients
    logic signed [W_BITS-1:0]    held_w = '0;
    logic [CNT_BITS-1:0]         wrap_total = '0;
    logic signed [COEF_BITS-1:0] b0_coef = B0_RESET;
    logic signed [COEF_BITS-1:0] b1_coef = B1_RESET;
    logic signed [COEF_BITS-1:0] a1_coef = A1_RESET;

    logic [IN_BITS-1:0] samples_to_send[$];
    filter_out_t        want_out[$];
    logic               in_taken = 1'b0;
    int                 send_gap_pct = 0;
    int                 sink_stall_pct = 0;
    int                 mismatches = 0;
    int                 outputs_checked = 0;
    int                 coef_sets = 1;
    longint             cycles = 0;

    iir_df2_first_order_filter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Wrap to the sample range, counting each wrap that changes the value
    function automatic longint wrap_sample(longint v);
        longint r;
        r = v & ((longint'(1) << SAMPLE_BITS) - 1);
        if (v < 0)
            r -= longint'(1) << SAMPLE_BITS;
        if (r != v && wrap_total != '1)
            wrap_total = wrap_total + 1'b1;
        return r;
    endfunction

    function automatic filter_out_t filter_step(logic signed [IN_BITS-1:0] x);
        longint w1, b0, b1, a1, xs, fb, ff, w, y;
        filter_out_t res;
        w1 = held_w;
        b0 = b0_coef;
        b1 = b1_coef;
        a1 = a1_coef;
        xs = x;
        fb = wrap_sample(-((w1 * a1) >>> SHIFT));
        ff = wrap_sample((w1 * b1) >>> SHIFT);
        w  = wrap_sample(xs + fb);
        y  = wrap_sample(((w * b0) >>> SHIFT) + ff);
        held_w = W_BITS'(w);
        res.sample = OUT_BITS'(y);
        res.count = wrap_total;
        return res;
    endfunction

    // Driver: present queued samples, hold an item until it is taken, drive m_tready with random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!(s_tvalid && !in_taken))
            begin
                if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= S_DATA_BITS'(samples_to_send.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Monitor: check results against the oldest prediction, predict on each accepted sample
    always @(posedge clk)
    begin
        filter_out_t got, exp_out;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
        in_taken <= s_tvalid && s_tready && rst_n;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sample = m_tdata[OUT_BITS-1:0];
            got.count = m_tdata[OUT_BITS +: CNT_BITS];
            if (want_out.size() == 0)
            begin
                mismatches++;
                $error("result with nothing expected: sample_out %0d", got.sample);
            end
            else
            begin
                exp_out = want_out.pop_front();
                outputs_checked++;
                if (got.sample !== exp_out.sample)
                begin
                    mismatches++;
                    $error("sample_out: expected %0d, got %0d", exp_out.sample, got.sample);
                end
                if (got.count !== exp_out.count)
                begin
                    mismatches++;
                    $error("overflow_count: expected %0d, got %0d",
                           exp_out.count, got.count);
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            want_out.push_back(filter_step($signed(s_tdata[IN_BITS-1:0])));
    end

    task automatic write_coef(logic [CFG_ADDR_BITS-1:0] idx, logic [COEF_BITS-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_B0: b0_coef = val;
            REG_B1: b1_coef = val;
            REG_A1: a1_coef = val;
            default: ;
        endcase
    endtask

    task automatic load_coefs(logic [COEF_BITS-1:0] b0, logic [COEF_BITS-1:0] b1,
                              logic [COEF_BITS-1:0] a1);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_A1, a1);
        @(negedge clk);
        cfg_we <= 1'b0;
        coef_sets++;
    endtask

    function automatic logic [COEF_BITS-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(COEF_BITS-1){1'b0}}};
            1: return {1'b0, {(COEF_BITS-1){1'b1}}};
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [IN_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(IN_BITS-1){1'b0}}};
            1: return {1'b0, {(IN_BITS-1){1'b1}}};
            default: return IN_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        repeat (n) samples_to_send.push_back(pick_sample());
    endtask

    // Let every queued sample through and every result come back, then settle
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_tvalid || want_out.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        int gap_mix[4] = '{0, 81, 0, 35};
        int stall_mix[4] = '{0, 0, 81, 35};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset coefficients, sample extremes and sign boundaries
        samples_to_send = '{12'h000, 12'h7ff, 12'h800, 12'h7ff, 12'h7ff,
                            12'hfff, 12'h001, 12'h800, 12'h800};
        wait_drained();

        // Most negative coefficients; a write to the unused index must be ignored
        load_coefs(12'h800, 12'h800, 12'h800);
        write_coef(REG_UNUSED, 12'h7ff);
        @(negedge clk);
        cfg_we <= 1'b0;
        samples_to_send = '{12'h7ff, 12'h800, 12'h7ff, 12'h000, 12'h800};
        wait_drained();

        // Most positive coefficients
        load_coefs(12'h7ff, 12'h7ff, 12'h7ff);
        samples_to_send = '{12'h7ff, 12'h7ff, 12'h800, 12'h800, 12'h001};
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            load_coefs(pick_coef(), pick_coef(), pick_coef());
            send_gap_pct = gap_mix[p];
            sink_stall_pct = stall_mix[p];
            queue_random(130);
            wait_drained();
        end

        // Keep the wrap counter climbing with extreme coefficients and inputs
        load_coefs(12'h800, 12'h800, 12'h800);
        send_gap_pct = 0;
        sink_stall_pct = 0;
        repeat (WRAP_ITEMS) samples_to_send.push_back(12'h800);
        wait_drained();
        send_gap_pct = 35;
        sink_stall_pct = 35;
        queue_random(100);
        wait_drained();

        $display("checked %0d filter outputs across %0d coefficient sets and four flow mixes,",
                 outputs_checked, coef_sets);
        $display("including a run of repeated wraps (final count %0d)", wrap_total);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
